// File: design/qpid_pkg.sv
// Shared types and constants of the four-channel incremental PID controller.
`timescale 1ns / 1ps
package qpid_pkg;
   localparam int NCH = 4;
   localparam int ERR_W = 17;
   localparam int ACC_W = 32;
   localparam int GAIN_W = 16;
   localparam int DRIVE_W = 24;
   localparam int OUTMAX_W = 23;
   // |acc| * limit stays below 2^62 whenever a rescale is due
   localparam int PROD_W = 62;

   localparam logic [1:0] CSR_KP = 2'd0;
   localparam logic [1:0] CSR_KI = 2'd1;
   localparam logic [1:0] CSR_KD = 2'd2;
   localparam logic [1:0] CSR_OUTMAX = 2'd3;

   // Datapath commands from the sequencer.
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,   // capture the input word
      CMD_MAC,    // one multiply-accumulate step of the increment
      CMD_ACC,    // saturate and store accumulator, shift history
      CMD_MAX,    // fold one channel into the running maximum
      CMD_DIVST,  // start rescale of one channel (multiply)
      CMD_DIV,    // one restoring-division step
      CMD_DIVEND  // store the quotient
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [1:0] ch;
      logic [1:0] term;
   } ctl_type;

   typedef struct packed {
      logic over;   // maximum exceeds limit
   } sts_type;
endpackage

// File: design/quad_incremental_pid_scaled_top.sv
// Top level of the four-channel incremental PID speed controller.
`timescale 1ns / 1ps
// Each request word carries four targets and four encoder readings; the block
// updates four Q24.8 drive accumulators with an incremental PID term, finds the
// largest absolute drive and, above out_max, rescales all four by
// out_max/maxabs (truncating toward zero). One response word with the four
// integer drives follows. The block takes no new request word until the
// response has been accepted. One shared 16x20 multiplier walks three terms
// per channel, the maximum is folded in one channel at a time, and each
// rescaled channel runs through a 62-step restoring divider.
// Registers: 0 kp, 1 ki, 2 kd (four Q8.8 gains each, channel 0 lowest), 3 out_max.
module quad_incremental_pid_scaled_top #(
   parameter int GAIN_FRACTION_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // target_0..3, measured_0..3 from bit 0 up, 16 bits each
   input  logic [127:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // drive_0..3 from bit 0 up, 24 bits each
   output logic [95:0]   rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [63:0]   csr_data
);
   qpid_pkg::ctl_type ctl;
   qpid_pkg::sts_type sts;
   logic busy, done;

   assign req_tready = !busy;
   assign rsp_tvalid = done;
   assign csr_ready  = 1'b1;

   qpid_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .start(req_tvalid && req_tready),
      .sts(sts), .rsp_taken(rsp_tready),
      .ctl(ctl), .busy(busy), .done(done)
   );

   qpid_dp #(.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl),
      .in_word(req_tdata),
      .csr_we(csr_valid), .csr_idx(csr_index), .csr_data(csr_data),
      .sts(sts), .drive_word(rsp_tdata)
   );
endmodule

// File: design/qpid_ctrl.sv
// Sequencer of the four-channel incremental PID controller.
`timescale 1ns / 1ps
module qpid_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  qpid_pkg::sts_type sts,
   input  logic             rsp_taken,
   output qpid_pkg::ctl_type ctl,
   output logic             busy,
   output logic             done
);
   typedef enum logic [2:0] {S_IDLE, S_MAC, S_ACC, S_MAX, S_DST, S_DIV, S_DEND, S_OUT}
      state_type;

   state_type state_ff, state_in;
   logic [1:0] ch_ff, ch_in;
   logic [1:0] term_ff, term_in;
   logic [5:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      term_in  = term_ff;
      step_in  = step_ff;
      ctl      = '{cmd: qpid_pkg::CMD_NONE, ch: ch_ff, term: term_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.cmd  = qpid_pkg::CMD_LOAD;
               state_in = S_MAC;
               ch_in    = '0;
               term_in  = '0;
            end
         end
         S_MAC: begin
            ctl.cmd = qpid_pkg::CMD_MAC;
            if (term_ff == 2'd2) begin
               term_in  = '0;
               state_in = S_ACC;
            end else begin
               term_in = term_ff + 2'd1;
            end
         end
         S_ACC: begin
            ctl.cmd = qpid_pkg::CMD_ACC;
            ch_in   = ch_ff + 2'd1;
            state_in = (ch_ff == 2'd3) ? S_MAX : S_MAC;
         end
         S_MAX: begin
            ctl.cmd = qpid_pkg::CMD_MAX;
            ch_in   = ch_ff + 2'd1;
            if (ch_ff == 2'd3) state_in = S_DST;
         end
         S_DST: begin
            if (!sts.over) begin
               state_in = S_OUT;
            end else begin
               ctl.cmd  = qpid_pkg::CMD_DIVST;
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            ctl.cmd = qpid_pkg::CMD_DIV;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(qpid_pkg::PROD_W - 1)) state_in = S_DEND;
         end
         S_DEND: begin
            ctl.cmd  = qpid_pkg::CMD_DIVEND;
            ch_in    = ch_ff + 2'd1;
            state_in = (ch_ff == 2'd3) ? S_OUT : S_DST;
         end
         S_OUT: begin
            if (rsp_taken) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ch_ff    <= '0;
         term_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         term_ff  <= term_in;
         step_ff  <= step_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_OUT);
endmodule

// File: design/qpid_dp.sv
// Datapath of the four-channel incremental PID controller.
`timescale 1ns / 1ps
module qpid_dp #(
   parameter int GAIN_FRACTION_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  qpid_pkg::ctl_type   ctl,
   input  logic [127:0]        in_word,
   input  logic                csr_we,
   input  logic [1:0]          csr_idx,
   input  logic [63:0]         csr_data,
   output qpid_pkg::sts_type   sts,
   output logic [95:0]         drive_word
);
   localparam int F = GAIN_FRACTION_BITS;
   localparam int LIM_W = qpid_pkg::OUTMAX_W + F;
   localparam int NUM_W = qpid_pkg::PROD_W;

   logic [63:0] kp_ff, ki_ff, kd_ff;
   logic [qpid_pkg::OUTMAX_W-1:0] omax_ff;
   logic signed [15:0] tgt_ff [qpid_pkg::NCH];
   logic signed [15:0] meas_ff [qpid_pkg::NCH];
   logic signed [qpid_pkg::ERR_W-1:0] e1_ff [qpid_pkg::NCH];
   logic signed [qpid_pkg::ERR_W-1:0] e2_ff [qpid_pkg::NCH];
   logic signed [qpid_pkg::ACC_W-1:0] acc_ff [qpid_pkg::NCH];
   logic signed [39:0] inc_ff;
   logic [32:0] max_ff;
   // division: remainder and shifting dividend/quotient register
   logic [NUM_W-1:0] dvd_ff;
   logic [33:0] rem_ff;
   logic        neg_ff;

   logic [1:0] c;
   logic signed [qpid_pkg::ERR_W-1:0] e, e1, e2;
   logic signed [19:0] opnd;
   logic signed [15:0] gsel;
   logic [63:0] gp;
   logic signed [35:0] prod;
   logic signed [40:0] sum;
   logic [32:0] absv;
   logic [LIM_W-1:0] limit;
   logic [32:0] mag;
   logic [NUM_W-1:0] num;
   logic [34:0] trial;

   assign c  = ctl.ch;
   assign e  = 17'(tgt_ff[c]) - 17'(meas_ff[c]);
   assign e1 = e1_ff[c];
   assign e2 = e2_ff[c];
   assign limit = LIM_W'(omax_ff) << F;
   assign absv = acc_ff[c][31] ? 33'(-34'(acc_ff[c])) : {1'b0, acc_ff[c]};
   assign sts.over = ({23'd0, max_ff} > 56'(limit));

   always_comb begin
      unique case (ctl.term)
         2'd0: begin gp = kp_ff; opnd = 20'(e) - 20'(e1); end
         2'd1: begin gp = ki_ff; opnd = 20'(e); end
         default: begin gp = kd_ff; opnd = 20'(e) - (20'(e1) <<< 1) + 20'(e2); end
      endcase
      gsel = gp[16*c +: 16];
      prod = 36'(gsel) * 36'(opnd);
      sum  = 41'(acc_ff[c]) + 41'(inc_ff);
      mag  = acc_ff[c][31] ? 33'(-34'(acc_ff[c])) : {1'b0, acc_ff[c]};
      num  = NUM_W'(mag) * NUM_W'(limit);
      trial = {rem_ff, dvd_ff[NUM_W-1]} - {2'b0, max_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0; ki_ff <= '0; kd_ff <= '0;
         omax_ff <= 23'd10000;
         for (int i = 0; i < qpid_pkg::NCH; i++) begin
            e1_ff[i] <= '0; e2_ff[i] <= '0; acc_ff[i] <= '0;
         end
         inc_ff <= '0;
         max_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_idx)
               qpid_pkg::CSR_KP: kp_ff <= csr_data;
               qpid_pkg::CSR_KI: ki_ff <= csr_data;
               qpid_pkg::CSR_KD: kd_ff <= csr_data;
               qpid_pkg::CSR_OUTMAX: omax_ff <= csr_data[22:0];
               default: ;
            endcase
         end
         unique case (ctl.cmd)
            qpid_pkg::CMD_LOAD: begin
               for (int i = 0; i < qpid_pkg::NCH; i++) begin
                  tgt_ff[i]  <= in_word[16*i +: 16];
                  meas_ff[i] <= in_word[64 + 16*i +: 16];
               end
               inc_ff <= '0;
               max_ff <= '0;
            end
            qpid_pkg::CMD_MAC: inc_ff <= inc_ff + 40'(prod);
            qpid_pkg::CMD_ACC: begin
               if (sum > 41'sh07FFFFFFF) acc_ff[c] <= 32'sh7FFFFFFF;
               else if (sum < -41'sh080000000) acc_ff[c] <= 32'sh80000000;
               else acc_ff[c] <= sum[31:0];
               e2_ff[c] <= e1;
               e1_ff[c] <= e;
               inc_ff   <= '0;
            end
            qpid_pkg::CMD_MAX: if (absv > max_ff) max_ff <= absv;
            qpid_pkg::CMD_DIVST: begin
               dvd_ff <= num;
               rem_ff <= '0;
               neg_ff <= acc_ff[c][31];
            end
            qpid_pkg::CMD_DIV: begin
               if (!trial[34]) begin
                  rem_ff <= trial[33:0];
                  dvd_ff <= {dvd_ff[NUM_W-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[32:0], dvd_ff[NUM_W-1]};
                  dvd_ff <= {dvd_ff[NUM_W-2:0], 1'b0};
               end
            end
            qpid_pkg::CMD_DIVEND:
               acc_ff[c] <= neg_ff ? 32'(-dvd_ff[31:0]) : dvd_ff[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < qpid_pkg::NCH; i++)
         drive_word[24*i +: 24] = 24'(acc_ff[i] >>> F);
   end
endmodule
